// ===== sv/write_stall_op_priority_controller_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Write stall op priority controller: assertion macros
// Shared concurrent assertion forms used by the checks in the top level.
// ----------------------------------------------------------------------------
`ifndef WRITE_STALL_OP_PRIORITY_CONTROLLER_UNIT_MACROS_SVH
`define WRITE_STALL_OP_PRIORITY_CONTROLLER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define WSOPC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("wsopc assertion failed");

// Next-cycle implication, checked outside reset.
`define WSOPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("wsopc assertion failed");

`endif

// ===== sv/wsopc_pkg.sv =====
// ----------------------------------------------------------------------------
// Write stall op priority controller package
// Shared codes, types and helper functions for controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wsopc_pkg;

  // Number of column families and the width of a family index.
  localparam int FAMILIES = 8;
  localparam int FAM_W = 3;
  localparam int TOKEN_COUNT_BITS = 16;

  // Field widths.
  localparam int MEM_W = 8;
  localparam int L0_W = 10;
  localparam int DEBT_W = 48;
  localparam int CFG_IDX_W = 2;

  // Reset values of the configuration registers.
  localparam logic [MEM_W-1:0] MEMTABLE_LIMIT_RST = MEM_W'(2);
  localparam logic [L0_W-1:0] L0_TRIGGER_RST = L0_W'(20);
  localparam logic [DEBT_W-1:0] DEBT_LIMIT_RST = DEBT_W'(64'd274877906944);

  typedef enum logic [1:0] {
    ACT_UPDATE  = 2'd0,
    ACT_REQUEST = 2'd1,
    ACT_RETURN  = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    OP_FLUSH  = 2'd0,
    OP_LEVEL0 = 2'd1,
    OP_DEEP   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    PRI_FREE = 2'd0,
    PRI_HIGH = 2'd1,
    PRI_LOW  = 2'd2,
    PRI_STOP = 2'd3
  } pri_e;

  typedef enum logic [1:0] {
    CU_NONE = 2'd0,
    CU_INC  = 2'd1,
    CU_DEC  = 2'd2,
    CU_KEEP = 2'd3
  } cushion_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MEMTABLE_LIMIT = 2'd0,
    CFG_L0_TRIGGER     = 2'd1,
    CFG_DEBT_LIMIT     = 2'd2,
    CFG_UNUSED         = 2'd3
  } cfg_idx_e;

  // Condition code bit positions.
  localparam int COND_MEM = 0;
  localparam int COND_L0 = 1;
  localparam int COND_DEBT = 2;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  // Priority of each background op kind for one family.
  typedef struct packed {
    logic [1:0] deep;
    logic [1:0] level0;
    logic [1:0] flush;
  } pri_table_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
  } dp_cmd_t;

  function automatic pri_table_t make_table(pri_e f, pri_e z, pri_e d);
    pri_table_t t;
    t.flush = f;
    t.level0 = z;
    t.deep = d;
    return t;
  endfunction

  localparam pri_table_t TABLE_RESET = '{deep: PRI_LOW, level0: PRI_HIGH, flush: PRI_FREE};

  // Cushion step: raised keeps or increases, cleared decays to none or decreases.
  function automatic logic [1:0] next_cushion(logic now, logic was_set,
                                              logic [1:0] prev_cu, logic safe);
    logic [1:0] r;
    if (now) begin
      r = was_set ? CU_KEEP : CU_INC;
    end else if (prev_cu == CU_NONE || safe) begin
      r = CU_NONE;
    end else begin
      r = CU_DEC;
    end
    return r;
  endfunction

  // Priority table refill from the new condition code and cushions.
  function automatic pri_table_t fill_table(logic [2:0] code, logic [3:0] cu);
    pri_table_t t;
    case (code) inside
      3'd0, 3'd1: begin
        if (cu == 4'd0) begin
          t = (code == 3'd0) ? TABLE_RESET : make_table(PRI_HIGH, PRI_LOW, PRI_LOW);
        end else if (cu[1:0] != CU_NONE) begin
          t = make_table(PRI_STOP, PRI_HIGH, PRI_LOW);
        end else begin
          t = make_table(PRI_LOW, PRI_STOP, PRI_HIGH);
        end
      end
      3'd4, 3'd5: begin
        t = make_table(PRI_LOW, PRI_STOP, PRI_HIGH);
      end
      default: begin
        t = make_table(PRI_STOP, PRI_HIGH, PRI_LOW);
      end
    endcase
    return t;
  endfunction

endpackage

// ===== sv/wsopc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Write stall op priority controller: sequencer
// Two-state controller that captures a word and runs it through the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsopc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy,
  output logic                done_o,
  output wsopc_pkg::dp_cmd_t  cmd_o
);
  import wsopc_pkg::*;

  state_e state_q, state_d;
  logic   done_q, done_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs to the datapath and the port side.
  always_comb begin
    cmd_o.capture = 1'b0;
    cmd_o.exec = 1'b0;
    busy = 1'b0;
    done_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.capture = start_i;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        busy = 1'b1;
        done_d = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // State and result strobe registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q <= done_d;
    end
  end

  assign done_o = done_q;

endmodule

// ===== sv/wsopc_datapath.sv =====
// ----------------------------------------------------------------------------
// Write stall op priority controller: datapath
// Configuration registers, per-family tables, token count and result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsopc_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  wsopc_pkg::dp_cmd_t                    cmd_i,
  input  logic [1:0]                            action_i,
  input  logic [wsopc_pkg::FAM_W-1:0]           family_index_i,
  input  logic [1:0]                            op_kind_i,
  input  logic [wsopc_pkg::MEM_W-1:0]           memtable_count_i,
  input  logic [wsopc_pkg::L0_W-1:0]            level0_files_i,
  input  logic [wsopc_pkg::DEBT_W-1:0]          debt_bytes_i,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [wsopc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [wsopc_pkg::DEBT_W-1:0]          cfg_data_i,
  output logic [1:0]                            priority_res_o,
  output logic                                  token_held_o,
  output logic [2:0]                            condition_code_o,
  output logic [1:0]                            level0_cushion_o,
  output logic [1:0]                            debt_cushion_o,
  output logic                                  high_count_zero_o
);
  import wsopc_pkg::*;

  // Configuration registers.
  logic [MEM_W-1:0]  mem_limit_q;
  logic [L0_W-1:0]   l0_trig_q;
  logic [DEBT_W-1:0] debt_limit_q;

  // Captured input word.
  logic [1:0]        action_q;
  logic [FAM_W-1:0]  fam_q;
  logic [1:0]        op_q;
  logic [MEM_W-1:0]  mem_q;
  logic [L0_W-1:0]   l0_q;
  logic [DEBT_W-1:0] debt_q;

  // Per-family state and the shared high token count.
  logic [2:0]             cond_q [FAMILIES];
  logic [3:0]             cu_q   [FAMILIES];
  pri_table_t             tbl_q  [FAMILIES];
  logic [TOKEN_COUNT_BITS-1:0] cnt_q, cnt_d;

  // Result registers.
  logic [1:0] res_pri_q, res_pri_d;
  logic       res_held_q, res_held_d;
  logic [2:0] res_code_q, res_code_d;
  logic [3:0] res_cu_q, res_cu_d;
  logic       res_zero_q, res_zero_d;

  // Exec-cycle combinational values.
  logic        fam_ok;
  logic [2:0]  cur_code;
  logic [3:0]  cur_cu;
  pri_table_t  cur_tbl;
  logic [2:0]  code_new;
  logic [3:0]  cu_new;
  pri_table_t  tbl_new;
  logic        upd_we;
  logic [1:0]  pri_sel;

  assign cfg_ready_o = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_limit_q <= MEMTABLE_LIMIT_RST;
      l0_trig_q <= L0_TRIGGER_RST;
      debt_limit_q <= DEBT_LIMIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MEMTABLE_LIMIT: mem_limit_q <= cfg_data_i[MEM_W-1:0];
        CFG_L0_TRIGGER:     l0_trig_q <= cfg_data_i[L0_W-1:0];
        CFG_DEBT_LIMIT:     debt_limit_q <= cfg_data_i;
        default:            mem_limit_q <= mem_limit_q;
      endcase
    end
  end

  // Input capture on accept.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      action_q <= action_i;
      fam_q <= family_index_i;
      op_q <= op_kind_i;
      mem_q <= memtable_count_i;
      l0_q <= level0_files_i;
      debt_q <= debt_bytes_i;
    end
  end

  // Family lookup and the status update computation.
  always_comb begin
    fam_ok = {1'b0, fam_q} < (FAM_W + 1)'(FAMILIES);
    cur_code = cond_q[fam_q];
    cur_cu = cu_q[fam_q];
    cur_tbl = tbl_q[fam_q];
    code_new[COND_MEM] = mem_q >= mem_limit_q;
    code_new[COND_L0] = l0_q >= l0_trig_q;
    code_new[COND_DEBT] = debt_q >= debt_limit_q;
    cu_new[1:0] = next_cushion(code_new[COND_L0], cur_code[COND_L0], cur_cu[1:0],
                               l0_q == '0);
    cu_new[3:2] = next_cushion(code_new[COND_DEBT], cur_code[COND_DEBT], cur_cu[3:2],
                               debt_q <= (debt_limit_q >> 1));
    tbl_new = fill_table(code_new, cu_new);
  end

  // Priority of the requested op kind.
  always_comb begin
    case (op_e'(op_q))
      OP_FLUSH:  pri_sel = cur_tbl.flush;
      OP_LEVEL0: pri_sel = cur_tbl.level0;
      OP_DEEP:   pri_sel = cur_tbl.deep;
      default:   pri_sel = PRI_FREE;
    endcase
  end

  // Action decode: result word, token count and table write enable.
  always_comb begin
    res_pri_d = PRI_FREE;
    res_held_d = 1'b0;
    res_code_d = '0;
    res_cu_d = '0;
    res_zero_d = 1'b0;
    cnt_d = cnt_q;
    upd_we = 1'b0;
    if (fam_ok) begin
      res_code_d = cur_code;
      res_cu_d = cur_cu;
      unique case (action_e'(action_q))
        ACT_UPDATE: begin
          upd_we = 1'b1;
          res_code_d = code_new;
          res_cu_d = cu_new;
        end
        ACT_REQUEST: begin
          res_pri_d = pri_sel;
          if (pri_sel == PRI_HIGH) begin
            res_held_d = 1'b1;
            if (!(&cnt_q)) begin
              cnt_d = cnt_q + TOKEN_COUNT_BITS'(1);
            end
          end
        end
        ACT_RETURN: begin
          if (cnt_q != '0) begin
            cnt_d = cnt_q - TOKEN_COUNT_BITS'(1);
          end
          res_zero_d = (cnt_d == '0);
        end
        default: begin
          res_pri_d = PRI_FREE;
        end
      endcase
    end
  end

  // Per-family tables and token count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FAMILIES; i++) begin
        cond_q[i] <= '0;
        cu_q[i] <= '0;
        tbl_q[i] <= TABLE_RESET;
      end
      cnt_q <= '0;
    end else if (cmd_i.exec) begin
      if (upd_we) begin
        cond_q[fam_q] <= code_new;
        cu_q[fam_q] <= cu_new;
        tbl_q[fam_q] <= tbl_new;
      end
      cnt_q <= cnt_d;
    end
  end

  // Result word register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_pri_q <= res_pri_d;
      res_held_q <= res_held_d;
      res_code_q <= res_code_d;
      res_cu_q <= res_cu_d;
      res_zero_q <= res_zero_d;
    end
  end

  assign priority_res_o = res_pri_q;
  assign token_held_o = res_held_q;
  assign condition_code_o = res_code_q;
  assign level0_cushion_o = res_cu_q[1:0];
  assign debt_cushion_o = res_cu_q[3:2];
  assign high_count_zero_o = res_zero_q;

endmodule

// ===== sv/write_stall_op_priority_controller_unit.sv =====
// A word is captured when accepted, run through the family table read-modify-write in
// the execute state, and its result is registered and strobed on done_o. The sequencer
// is busy in the execute state and takes no new word until it is back in idle.
// Results are shown for one cycle; the receiver cannot stall.
// Reset clears the sequencer, token count, family tables and restores configuration.
// ----------------------------------------------------------------------------
// Write stall op priority controller
// Top level joining the sequencer and the per-family priority datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "write_stall_op_priority_controller_unit_macros.svh"

module write_stall_op_priority_controller_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  output logic                              done_o,
  input  logic [1:0]                        action_i,
  input  logic [wsopc_pkg::FAM_W-1:0]       family_index_i,
  input  logic [1:0]                        op_kind_i,
  input  logic [wsopc_pkg::MEM_W-1:0]       memtable_count_i,
  input  logic [wsopc_pkg::L0_W-1:0]        level0_files_i,
  input  logic [wsopc_pkg::DEBT_W-1:0]      debt_bytes_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [wsopc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [wsopc_pkg::DEBT_W-1:0]      cfg_data_i,
  output logic [1:0]                        priority_res_o,
  output logic                              token_held_o,
  output logic [2:0]                        condition_code_o,
  output logic [1:0]                        level0_cushion_o,
  output logic [1:0]                        debt_cushion_o,
  output logic                              high_count_zero_o
);
  import wsopc_pkg::*;

  dp_cmd_t cmd;

  // Sequencer.
  wsopc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy    (busy),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  // Datapath.
  wsopc_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .action_i          (action_i),
    .family_index_i    (family_index_i),
    .op_kind_i         (op_kind_i),
    .memtable_count_i  (memtable_count_i),
    .level0_files_i    (level0_files_i),
    .debt_bytes_i      (debt_bytes_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .priority_res_o    (priority_res_o),
    .token_held_o      (token_held_o),
    .condition_code_o  (condition_code_o),
    .level0_cushion_o  (level0_cushion_o),
    .debt_cushion_o    (debt_cushion_o),
    .high_count_zero_o (high_count_zero_o)
  );

  // An accepted word always goes busy, and busy always ends in a strobe.
  `WSOPC_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  `WSOPC_ASSERT_NEXT(a_busy_done, clk_i, rst_ni, busy, done_o && !busy)
  // A held token is only reported with a high priority.
  `WSOPC_ASSERT_IMPLIES(a_held_high, clk_i, rst_ni, done_o && token_held_o, priority_res_o == PRI_HIGH)
  // A wake flag never comes with a request grant.
  `WSOPC_ASSERT_IMPLIES(a_zero_no_grant, clk_i, rst_ni, done_o && high_count_zero_o, !token_held_o && priority_res_o == PRI_FREE)

endmodule

// ===== verif/tb_write_stall_op_priority_controller_unit.sv =====
// ----------------------------------------------------------------------------
// Write stall op priority controller testbench
// Drives status updates, token requests and token returns through the start
// and busy handshake, mirrors the per-family condition, cushion and priority
// state in a scoreboard, and checks every strobed result word field by field.
// Runs several register settings, the extremes among them, and ends with a
// short run of high grants and returns on the shared token count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_write_stall_op_priority_controller_unit;
  import wsopc_pkg::*;

  localparam logic [TOKEN_COUNT_BITS-1:0] TOKENS_FULL = '1;
  localparam logic [DEBT_W-1:0] DEBT_ALL_ONES = '1;

  // One input word as the sender sees it.
  typedef struct {
    action_e           action;
    logic [FAM_W-1:0]  fam;
    op_e               op;
    logic [MEM_W-1:0]  mem;
    logic [L0_W-1:0]   l0;
    logic [DEBT_W-1:0] debt;
  } stall_word_t;

  // One result word, kept as plain bits so unknowns stay visible.
  typedef struct {
    logic [1:0] pri;
    logic       held;
    logic [2:0] cond;
    logic [1:0] l0_cu;
    logic [1:0] debt_cu;
    logic       zero;
  } grant_word_t;

  // Scoreboard: mirrors the family tables and the token count, and holds the
  // result words still owed by the block.
  class family_priority_board;
    logic [MEM_W-1:0]            mem_limit;
    logic [L0_W-1:0]             l0_trigger;
    logic [DEBT_W-1:0]           debt_limit;
    logic [2:0]                  cond [FAMILIES];
    cushion_e                    l0_cu [FAMILIES];
    cushion_e                    debt_cu [FAMILIES];
    pri_e                        prio [FAMILIES][3];
    logic [TOKEN_COUNT_BITS-1:0] tokens;
    grant_word_t                 owed_words [$];
    int unsigned                 mismatch_count;

    function new();
      mem_limit = MEMTABLE_LIMIT_RST;
      l0_trigger = L0_TRIGGER_RST;
      debt_limit = DEBT_LIMIT_RST;
      tokens = '0;
      mismatch_count = 0;
      for (int f = 0; f < FAMILIES; f++) begin
        cond[f] = 3'd0;
        l0_cu[f] = CU_NONE;
        debt_cu[f] = CU_NONE;
        set_table(f, PRI_FREE, PRI_HIGH, PRI_LOW);
      end
    endfunction

    function void set_table(int f, pri_e fl, pri_e z, pri_e d);
      prio[f][OP_FLUSH] = fl;
      prio[f][OP_LEVEL0] = z;
      prio[f][OP_DEEP] = d;
    endfunction

    // A raised condition keeps or grows its cushion; a cleared one decays.
    function cushion_e step_cushion(logic now, logic was, cushion_e prev, logic safe);
      if (now) return was ? CU_KEEP : CU_INC;
      if (prev == CU_NONE || safe) return CU_NONE;
      return CU_DEC;
    endfunction

    // Priority refill from the new code and cushions.
    function void refill(int f);
      case (cond[f])
        3'd0, 3'd1: begin
          if (l0_cu[f] == CU_NONE && debt_cu[f] == CU_NONE) begin
            if (cond[f] == 3'd0) set_table(f, PRI_FREE, PRI_HIGH, PRI_LOW);
            else set_table(f, PRI_HIGH, PRI_LOW, PRI_LOW);
          end else if (l0_cu[f] != CU_NONE) begin
            set_table(f, PRI_STOP, PRI_HIGH, PRI_LOW);
          end else begin
            set_table(f, PRI_LOW, PRI_STOP, PRI_HIGH);
          end
        end
        3'd4, 3'd5: set_table(f, PRI_LOW, PRI_STOP, PRI_HIGH);
        default: set_table(f, PRI_STOP, PRI_HIGH, PRI_LOW);
      endcase
    endfunction

    function void note_config(cfg_idx_e idx, logic [DEBT_W-1:0] data);
      case (idx)
        CFG_MEMTABLE_LIMIT: mem_limit = data[MEM_W-1:0];
        CFG_L0_TRIGGER:     l0_trigger = data[L0_W-1:0];
        CFG_DEBT_LIMIT:     debt_limit = data;
        default: ;
      endcase
    endfunction

    // Accepted input word: advance the mirror state and queue the result.
    function void note_word(stall_word_t w);
      grant_word_t g;
      logic [2:0] prev;
      int f;
      f = w.fam;
      g = '{pri: PRI_FREE, held: 1'b0, cond: 3'd0, l0_cu: CU_NONE,
            debt_cu: CU_NONE, zero: 1'b0};
      case (w.action)
        ACT_UPDATE: begin
          prev = cond[f];
          cond[f] = {w.debt >= debt_limit, w.l0 >= l0_trigger, w.mem >= mem_limit};
          l0_cu[f] = step_cushion(cond[f][COND_L0], prev[COND_L0], l0_cu[f],
                                  w.l0 == '0);
          debt_cu[f] = step_cushion(cond[f][COND_DEBT], prev[COND_DEBT], debt_cu[f],
                                    w.debt <= (debt_limit >> 1));
          refill(f);
        end
        ACT_REQUEST: begin
          if (w.op != OP_NONE) begin
            g.pri = prio[f][w.op];
            if (prio[f][w.op] == PRI_HIGH) begin
              g.held = 1'b1;
              if (tokens != TOKENS_FULL) tokens++;
            end
          end
        end
        ACT_RETURN: begin
          if (tokens != '0) tokens--;
          g.zero = (tokens == '0);
        end
        default: ;
      endcase
      g.cond = cond[f];
      g.l0_cu = l0_cu[f];
      g.debt_cu = debt_cu[f];
      owed_words = {owed_words, g};
    endfunction

    function void check_word(grant_word_t got);
      grant_word_t exp;
      if (owed_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result word: pri %0d held %0d cond %0d cushions %0d/%0d zero %0d",
                   got.pri, got.held, got.cond, got.l0_cu, got.debt_cu, got.zero);
        return;
      end
      exp = owed_words[0];
      owed_words.delete(0);
      if (got.pri !== exp.pri || got.held !== exp.held || got.cond !== exp.cond ||
          got.l0_cu !== exp.l0_cu || got.debt_cu !== exp.debt_cu ||
          got.zero !== exp.zero) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result mismatch at %0t: expected pri %0d held %0d cond %0d cushions %0d/%0d zero %0d, got pri %0d held %0d cond %0d cushions %0d/%0d zero %0d",
                   $realtime, exp.pri, exp.held, exp.cond, exp.l0_cu, exp.debt_cu, exp.zero,
                   got.pri, got.held, got.cond, got.l0_cu, got.debt_cu, got.zero);
      end
    endfunction

    function int pending();
      return owed_words.size();
    endfunction

    // The op that currently holds the high priority in a family.
    function op_e high_op(int f);
      for (int k = 0; k < 3; k++)
        if (prio[f][k] == PRI_HIGH) return op_e'(k);
      return OP_LEVEL0;
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic                  done_o;
  logic [1:0]            action_i;
  logic [FAM_W-1:0]      family_index_i;
  logic [1:0]            op_kind_i;
  logic [MEM_W-1:0]      memtable_count_i;
  logic [L0_W-1:0]       level0_files_i;
  logic [DEBT_W-1:0]     debt_bytes_i;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [DEBT_W-1:0]     cfg_data_i;
  logic [1:0]            priority_res_o;
  logic                  token_held_o;
  logic [2:0]            condition_code_o;
  logic [1:0]            level0_cushion_o;
  logic [1:0]            debt_cushion_o;
  logic                  high_count_zero_o;

  family_priority_board board;

  write_stall_op_priority_controller_unit u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .done_o            (done_o),
    .action_i          (action_i),
    .family_index_i    (family_index_i),
    .op_kind_i         (op_kind_i),
    .memtable_count_i  (memtable_count_i),
    .level0_files_i    (level0_files_i),
    .debt_bytes_i      (debt_bytes_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .priority_res_o    (priority_res_o),
    .token_held_o      (token_held_o),
    .condition_code_o  (condition_code_o),
    .level0_cushion_o  (level0_cushion_o),
    .debt_cushion_o    (debt_cushion_o),
    .high_count_zero_o (high_count_zero_o)
  );

  // 4 ns clock.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Result words are strobed for one cycle and taken at the closing edge.
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      board.check_word('{pri: priority_res_o, held: token_held_o, cond: condition_code_o,
                         l0_cu: level0_cushion_o, debt_cu: debt_cushion_o,
                         zero: high_count_zero_o});
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic stall_word_t mk(action_e a, int f, op_e o, logic [MEM_W-1:0] m,
                                     logic [L0_W-1:0] z, logic [DEBT_W-1:0] d);
    stall_word_t w;
    w.action = a;
    w.fam = f[FAM_W-1:0];
    w.op = o;
    w.mem = m;
    w.l0 = z;
    w.debt = d;
    return w;
  endfunction

  function automatic logic [DEBT_W-1:0] rand_debt_bits();
    return DEBT_W'({$urandom(), $urandom()});
  endfunction

  // Random word, with the status fields pulled toward the current thresholds.
  function automatic stall_word_t random_word();
    stall_word_t w;
    int unsigned r;
    r = $urandom_range(0, 99);
    w.action = (r < 35) ? ACT_UPDATE : (r < 70) ? ACT_REQUEST : (r < 93) ? ACT_RETURN
                                                                         : ACT_NONE;
    w.fam = ($urandom_range(0, 99) < 70) ? FAM_W'($urandom_range(0, 2))
                                         : FAM_W'($urandom_range(0, 7));
    w.op = ($urandom_range(0, 11) == 0) ? OP_NONE : op_e'($urandom_range(0, 2));
    case ($urandom_range(0, 4))
      0: w.mem = board.mem_limit;
      1: w.mem = board.mem_limit - 1'b1;
      2: w.mem = '0;
      default: w.mem = MEM_W'($urandom());
    endcase
    case ($urandom_range(0, 5))
      0: w.l0 = board.l0_trigger;
      1: w.l0 = board.l0_trigger - 1'b1;
      2, 3: w.l0 = '0;
      4: w.l0 = L0_W'($urandom_range(0, 3));
      default: w.l0 = L0_W'($urandom());
    endcase
    case ($urandom_range(0, 6))
      0: w.debt = board.debt_limit;
      1: w.debt = board.debt_limit - 1'b1;
      2: w.debt = board.debt_limit >> 1;
      3: w.debt = (board.debt_limit >> 1) + 1'b1;
      4: w.debt = DEBT_W'(64'(rand_debt_bits()) % (64'(board.debt_limit) + 64'd1));
      default: w.debt = rand_debt_bits();
    endcase
    return w;
  endfunction

  // Present one word and hold it until the block takes it. Start is left high.
  task automatic send_word(stall_word_t w);
    start <= 1'b1;
    action_i <= w.action;
    family_index_i <= w.fam;
    op_kind_i <= w.op;
    memtable_count_i <= w.mem;
    level0_files_i <= w.l0;
    debt_bytes_i <= w.debt;
    do @(posedge clk_i); while (busy !== 1'b0);
    board.note_word(w);
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Wait for every owed result word, then let the block run idle before going on.
  task automatic settle();
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [DEBT_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    board.note_config(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_setting(logic [MEM_W-1:0] m, logic [L0_W-1:0] z,
                               logic [DEBT_W-1:0] d);
    write_reg(CFG_MEMTABLE_LIMIT, DEBT_W'(m));
    write_reg(CFG_L0_TRIGGER, DEBT_W'(z));
    write_reg(CFG_DEBT_LIMIT, d);
  endtask

  // Random words in bursts, with random gaps or none between them.
  task automatic run_random(int n);
    int sent;
    int burst;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 30);
      for (int k = 0; k < burst && sent < n; k++) begin
        send_word(random_word());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
    end
  endtask

  initial begin
    board = new();
    rst_ni <= 1'b0;
    start <= 1'b0;
    action_i <= ACT_UPDATE;
    family_index_i <= '0;
    op_kind_i <= OP_FLUSH;
    memtable_count_i <= '0;
    level0_files_i <= '0;
    debt_bytes_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_MEMTABLE_LIMIT;
    cfg_data_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words at the reset settings.
    // Requests on a family never updated, every op, then returns down past zero.
    send_word(mk(ACT_REQUEST, 0, OP_FLUSH, 0, 0, 0));
    send_word(mk(ACT_REQUEST, 0, OP_LEVEL0, 0, 0, 0));
    send_word(mk(ACT_REQUEST, 0, OP_DEEP, 0, 0, 0));
    send_word(mk(ACT_REQUEST, 0, OP_NONE, 0, 0, 0));
    send_word(mk(ACT_RETURN, 0, OP_FLUSH, 0, 0, 0));
    send_word(mk(ACT_RETURN, 0, OP_FLUSH, 0, 0, 0));
    send_word(mk(ACT_NONE, 1, OP_NONE, '1, '1, '1));
    // All conditions raised, held, then cleared above and at the safe points.
    send_word(mk(ACT_UPDATE, 2, OP_FLUSH, '1, '1, '1));
    send_word(mk(ACT_UPDATE, 2, OP_FLUSH, '1, '1, '1));
    send_word(mk(ACT_REQUEST, 2, OP_FLUSH, 0, 0, 0));
    send_word(mk(ACT_REQUEST, 2, OP_LEVEL0, 0, 0, 0));
    send_word(mk(ACT_RETURN, 2, OP_FLUSH, 0, 0, 0));
    send_word(mk(ACT_UPDATE, 2, OP_FLUSH, 0, 5, (DEBT_LIMIT_RST >> 1) + 1'b1));
    send_word(mk(ACT_UPDATE, 2, OP_FLUSH, 0, 5, DEBT_LIMIT_RST >> 1));
    send_word(mk(ACT_UPDATE, 2, OP_FLUSH, 1, 0, 0));
    // Memory alone, debt alone with its decay, level-0 alone with its decay.
    send_word(mk(ACT_UPDATE, 3, OP_FLUSH, MEMTABLE_LIMIT_RST, 0, 0));
    send_word(mk(ACT_REQUEST, 3, OP_FLUSH, 0, 0, 0));
    send_word(mk(ACT_UPDATE, 4, OP_FLUSH, 0, 0, DEBT_LIMIT_RST));
    send_word(mk(ACT_UPDATE, 4, OP_FLUSH, 0, 0, DEBT_LIMIT_RST - 1'b1));
    send_word(mk(ACT_REQUEST, 4, OP_DEEP, 0, 0, 0));
    send_word(mk(ACT_UPDATE, 5, OP_FLUSH, 0, L0_TRIGGER_RST, 0));
    send_word(mk(ACT_UPDATE, 5, OP_FLUSH, '1, L0_TRIGGER_RST - 1'b1, 0));
    send_word(mk(ACT_NONE, 5, OP_NONE, 0, 0, 0));
    send_word(mk(ACT_RETURN, 7, OP_DEEP, 0, 0, 0));
    send_word(mk(ACT_RETURN, 6, OP_DEEP, 0, 0, 0));
    settle();

    // Random phases over several register settings: the reset settings, the extremes, then random ones.
    write_setting(MEMTABLE_LIMIT_RST, L0_TRIGGER_RST, DEBT_LIMIT_RST);
    write_reg(CFG_UNUSED, rand_debt_bits());
    run_random(340);
    settle();
    write_setting(8'd1, 10'd1, '0);
    run_random(340);
    settle();
    write_setting('1, '1, DEBT_ALL_ONES);
    run_random(340);
    settle();
    write_setting(MEM_W'($urandom_range(1, 8)), L0_W'($urandom_range(1, 40)),
                  rand_debt_bits() >> $urandom_range(0, 40));
    run_random(340);
    settle();
    write_setting(MEM_W'($urandom_range(1, 255)), L0_W'($urandom_range(1, 1023)),
                  rand_debt_bits());
    run_random(340);
    settle();

    // A short run of high grants on the shared count, then returns.
    repeat (3) send_word(mk(ACT_REQUEST, 0, board.high_op(0), 0, 0, 0));
    repeat (3) send_word(mk(ACT_RETURN, 0, OP_FLUSH, 0, 0, 0));
    settle();

    if (board.mismatch_count == 0 && board.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
